// ===== src/gha_pkg.sv =====
// shared types and constants for the generational handle allocator
// no dependencies; compiled first

package gha_pkg;

    localparam int REQ_IDX_W         = 10;
    localparam int GEN_W             = 32;
    localparam int CMD_W             = 2;
    localparam int STATUS_W          = 2;
    localparam int DEFAULT_MAX_SLOTS = 1024;

    localparam logic [CMD_W-1:0] CMD_CREATE    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CREATE_AT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DESTROY   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY     = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BEYOND = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_POP,
        ST_EXEC,
        ST_COMPACT
    } ctrl_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic look;
        logic pop;
        logic exec;
        logic compact;
        logic clear;
    } dp_ctl_t;

    // status from datapath to controller
    typedef struct packed {
        logic need_pop;
        logic need_compact;
        logic out_busy;
        logic clear_done;
        logic compact_done;
    } dp_stat_t;

endpackage

// ===== src/gha_req_if.sv =====
// request channel: valid/ready handshake carrying one command word
// depends on gha_pkg

interface gha_req_if;
    logic                          valid;
    logic                          ready;
    logic [gha_pkg::CMD_W-1:0]     cmd;
    logic [gha_pkg::REQ_IDX_W-1:0] req_index;
    logic [gha_pkg::GEN_W-1:0]     req_generation;

    modport source (output valid, cmd, req_index, req_generation, input ready);
    modport sink   (input valid, cmd, req_index, req_generation, output ready);
endinterface

// ===== src/gha_res_if.sv =====
// result channel: valid/ready handshake carrying one result word
// depends on gha_pkg

interface gha_res_if;
    logic                          valid;
    logic                          ready;
    logic [gha_pkg::REQ_IDX_W-1:0] res_index;
    logic [gha_pkg::GEN_W-1:0]     res_generation;
    logic                          is_alive;
    logic [gha_pkg::STATUS_W-1:0]  status;

    modport source (output valid, res_index, res_generation, is_alive, status, input ready);
    modport sink   (input valid, res_index, res_generation, is_alive, status, output ready);
endinterface

// ===== src/gha_ctrl.sv =====
// sequencing state machine for the handle allocator
// depends on gha_pkg; drives the datapath through dp_ctl_t

module gha_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  gha_pkg::dp_stat_t stat,
    output gha_pkg::dp_ctl_t  ctl
);
    import gha_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ctl.clear = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                ctl.look   = 1'b1;
                state_next = stat.need_pop ? ST_POP : ST_EXEC;
            end
            ST_POP:
            begin
                ctl.pop    = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (!stat.out_busy)
                begin
                    ctl.exec   = 1'b1;
                    state_next = stat.need_compact ? ST_COMPACT : ST_IDLE;
                end
            end
            ST_COMPACT:
            begin
                ctl.compact = 1'b1;
                if (stat.compact_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// ===== src/gha_datapath.sv =====
// generation table, free stack, counters and result register
// depends on gha_pkg and gha_res_if; steered by gha_ctrl

module gha_datapath #(
    parameter int MAX_SLOTS = gha_pkg::DEFAULT_MAX_SLOTS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [gha_pkg::CMD_W-1:0]     req_cmd,
    input  logic [gha_pkg::REQ_IDX_W-1:0] req_index,
    input  logic [gha_pkg::GEN_W-1:0]     req_generation,
    gha_res_if.source                     res,
    input  gha_pkg::dp_ctl_t              ctl,
    output gha_pkg::dp_stat_t             stat
);
    import gha_pkg::*;

    localparam int AW = $clog2(MAX_SLOTS);
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int XW = (CW > REQ_IDX_W) ? CW : REQ_IDX_W;

    logic [GEN_W-1:0] gen_mem [MAX_SLOTS];
    logic [AW-1:0]    stk_mem [MAX_SLOTS];

    // request word
    logic [CMD_W-1:0]     cmd_reg;
    logic [REQ_IDX_W-1:0] idx_reg;
    logic [GEN_W-1:0]     gen_reg;

    // control state
    logic [CW-1:0] used_reg, used_next;
    logic [CW-1:0] depth_reg, depth_next;
    logic [AW-1:0] clr_ptr_reg, clr_ptr_next;
    logic [CW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] keep_reg, keep_next;
    logic          pend_reg, pend_next;
    logic          out_valid_reg, out_valid_next;

    // memory read data
    logic [GEN_W-1:0] gen_rd_reg;
    logic [AW-1:0]    stk_rd_reg;

    // result word
    logic [REQ_IDX_W-1:0] res_idx_reg, res_idx_next;
    logic [GEN_W-1:0]     res_gen_reg, res_gen_next;
    logic                 res_alive_reg, res_alive_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;

    // memory ports
    logic             gen_we, gen_re;
    logic [AW-1:0]    gen_waddr, gen_raddr;
    logic [GEN_W-1:0] gen_wdata;
    logic             stk_we, stk_re;
    logic [AW-1:0]    stk_waddr, stk_raddr;
    logic [AW-1:0]    stk_wdata;

    logic          beyond, below_used, alive, live_at, reading, taken;
    logic [AW-1:0] idx_a;

    assign idx_a      = AW'(idx_reg);
    assign beyond     = XW'(idx_reg) >= XW'(MAX_SLOTS);
    assign below_used = XW'(idx_reg) < XW'(used_reg);
    assign alive      = !beyond && below_used && (gen_rd_reg == gen_reg);
    // create_at covers the index first, so only the generation decides
    assign live_at    = gen_rd_reg == gen_reg;
    assign reading    = rd_ptr_reg != depth_reg;
    assign taken      = out_valid_reg && res.ready;

    assign stat.need_pop     = (cmd_reg == CMD_CREATE) && (depth_reg != '0);
    assign stat.need_compact = (cmd_reg == CMD_CREATE_AT) && !beyond && !live_at;
    assign stat.out_busy     = out_valid_reg && !res.ready;
    assign stat.clear_done   = clr_ptr_reg == AW'(MAX_SLOTS - 1);
    assign stat.compact_done = !reading && !pend_reg;

    always_comb
    begin
        used_next       = used_reg;
        depth_next      = depth_reg;
        clr_ptr_next    = clr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        keep_next       = keep_reg;
        pend_next       = pend_reg;
        out_valid_next  = taken ? 1'b0 : out_valid_reg;
        res_idx_next    = res_idx_reg;
        res_gen_next    = res_gen_reg;
        res_alive_next  = res_alive_reg;
        res_status_next = res_status_reg;
        gen_we          = 1'b0;
        gen_waddr       = idx_a;
        gen_wdata       = gen_reg;
        gen_re          = 1'b0;
        gen_raddr       = idx_a;
        stk_we          = 1'b0;
        stk_waddr       = AW'(depth_reg);
        stk_wdata       = idx_a;
        stk_re          = 1'b0;
        stk_raddr       = AW'(depth_reg - CW'(1));

        if (ctl.clear)
        begin
            gen_we       = 1'b1;
            gen_waddr    = clr_ptr_reg;
            gen_wdata    = '0;
            clr_ptr_next = clr_ptr_reg + AW'(1);
        end

        if (ctl.look)
        begin
            gen_re = 1'b1;
            stk_re = 1'b1;
        end

        if (ctl.pop)
        begin
            gen_re    = 1'b1;
            gen_raddr = stk_rd_reg;
        end

        if (ctl.exec)
        begin
            out_valid_next  = 1'b1;
            res_idx_next    = idx_reg;
            res_gen_next    = gen_reg;
            res_alive_next  = 1'b0;
            res_status_next = STATUS_OK;
            rd_ptr_next     = '0;
            keep_next       = '0;
            pend_next       = 1'b0;
            if (cmd_reg == CMD_CREATE)
            begin
                if (depth_reg != '0)
                begin
                    depth_next   = depth_reg - CW'(1);
                    res_idx_next = REQ_IDX_W'(stk_rd_reg);
                    res_gen_next = gen_rd_reg;
                end
                else if (used_reg != CW'(MAX_SLOTS))
                begin
                    gen_we       = 1'b1;
                    gen_waddr    = AW'(used_reg);
                    gen_wdata    = '0;
                    used_next    = used_reg + CW'(1);
                    res_idx_next = REQ_IDX_W'(used_reg);
                    res_gen_next = '0;
                end
                else
                begin
                    res_idx_next    = '0;
                    res_gen_next    = '0;
                    res_status_next = STATUS_FULL;
                end
            end
            else if (beyond)
            begin
                res_status_next = STATUS_BEYOND;
            end
            else
            begin
                case (cmd_reg)
                    CMD_CREATE_AT:
                    begin
                        if (!below_used)
                        begin
                            used_next = CW'(idx_a) + CW'(1);
                        end
                        res_alive_next = live_at;
                        if (!live_at)
                        begin
                            gen_we = 1'b1;
                        end
                    end
                    CMD_DESTROY:
                    begin
                        res_alive_next = alive;
                        if (alive)
                        begin
                            gen_we    = 1'b1;
                            gen_wdata = gen_rd_reg + GEN_W'(1);
                            if (depth_reg != CW'(MAX_SLOTS))
                            begin
                                stk_we     = 1'b1;
                                depth_next = depth_reg + CW'(1);
                            end
                        end
                    end
                    default:
                    begin
                        res_alive_next = alive;
                    end
                endcase
            end
        end

        // stable compaction: read ahead one entry, write kept entries behind
        if (ctl.compact)
        begin
            stk_re      = reading;
            stk_raddr   = AW'(rd_ptr_reg);
            pend_next   = reading;
            rd_ptr_next = reading ? rd_ptr_reg + CW'(1) : rd_ptr_reg;
            if (pend_reg && (stk_rd_reg != idx_a))
            begin
                stk_we    = 1'b1;
                stk_waddr = AW'(keep_reg);
                stk_wdata = stk_rd_reg;
                keep_next = keep_reg + CW'(1);
            end
            if (!reading && !pend_reg)
            begin
                depth_next = keep_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            depth_reg     <= '0;
            clr_ptr_reg   <= '0;
            rd_ptr_reg    <= '0;
            keep_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            depth_reg     <= depth_next;
            clr_ptr_reg   <= clr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            keep_reg      <= keep_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= req_cmd;
            idx_reg <= req_index;
            gen_reg <= req_generation;
        end
        res_idx_reg    <= res_idx_next;
        res_gen_reg    <= res_gen_next;
        res_alive_reg  <= res_alive_next;
        res_status_reg <= res_status_next;
    end

    always_ff @(posedge clk)
    begin
        if (gen_we)
        begin
            gen_mem[gen_waddr] <= gen_wdata;
        end
        if (gen_re)
        begin
            gen_rd_reg <= gen_mem[gen_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re)
        begin
            stk_rd_reg <= stk_mem[stk_raddr];
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.res_index      = res_idx_reg;
    assign res.res_generation = res_gen_reg;
    assign res.is_alive       = res_alive_reg;
    assign res.status         = res_status_reg;

endmodule

// ===== src/generational_handle_allocator.sv =====
// Generational handle allocator: issues handles of a slot index and a 32-bit generation,
// one result word per command (create, create_at, destroy, query). After reset the
// generation table is swept to zero, one slot a cycle; no command word is taken during
// that sweep. Commands are then handled one at a time through a generation table and a
// free stack, each with a registered read: query, destroy, a create that grows the slot
// count and create_at read the table, load the result register and return to idle for
// the next command; create from the free stack first reads the stack, then the table.
// Create_at of a dead handle then adds a walk of the free stack, during which no new
// command is taken. A result not yet taken stalls the next command before it loads the
// result register, until that result word is taken.
// depends on gha_pkg, gha_req_if, gha_res_if, gha_ctrl and gha_datapath

module generational_handle_allocator #(
    parameter int MAX_SLOTS = gha_pkg::DEFAULT_MAX_SLOTS
) (
    input  logic    clk,
    input  logic    rst_n,
    gha_req_if.sink req,
    gha_res_if.source res
);
    import gha_pkg::*;

    dp_ctl_t  ctl;
    dp_stat_t stat;
    logic     ready;

    assign req.ready = ready;

    gha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    gha_datapath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_cmd        (req.cmd),
        .req_index      (req.req_index),
        .req_generation (req.req_generation),
        .res            (res),
        .ctl            (ctl),
        .stat           (stat)
    );

endmodule
